// ----- sv/dtfi_pkg.sv -----
// Shared types, widths and breakpoint tables for the distance-to-focus interpolator.
// Used by dtfi_search, dtfi_mul, dtfi_div and distance_to_focus_interp.
`timescale 1ns / 1ps
`default_nettype none

package dtfi_pkg;

    // Breakpoint table size and output scaling
    localparam int NUM_POINTS = 11;
    localparam int OUT_SCALE  = 2048;
    localparam int POS_ONE    = 65536;
    localparam int SCALE_DIV  = POS_ONE / OUT_SCALE;

    // Field widths
    localparam int DIST_W  = 21;                  // distance_mm, signed
    localparam int POS_W   = 17;                  // Q0.16 position, 1.0 included
    localparam int FOCUS_W = 12;                  // focus_code

    // Datapath widths
    localparam int T_W    = DIST_W + 1;           // distance offset within a segment
    localparam int DP_W   = POS_W + 1;            // signed position step of a segment
    localparam int BASE_W = POS_W + T_W;          // p0 * span
    localparam int PROD_W = T_W + 1 + DP_W;       // serial product
    localparam int X_W    = PROD_W;               // interpolation numerator, signed
    localparam int MAG_W  = X_W - 1;              // numerator magnitude
    localparam int D_W    = T_W + $clog2(SCALE_DIV); // divisor span * SCALE_DIV
    localparam int Q_W    = FOCUS_W;              // quotient bits
    localparam int HI_W   = MAG_W - Q_W;          // dividend bits above the quotient
    localparam int K_W    = $clog2(NUM_POINTS);   // breakpoint index

    // Stream widths
    localparam int IN_TDATA_W  = ((DIST_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((FOCUS_W + 7) / 8) * 8;

    localparam logic [FOCUS_W-1:0] OUT_CODE = FOCUS_W'(OUT_SCALE);

    // Breakpoints: strictly increasing distance (mm), position as Q0.16
    localparam int DIST_TABLE [NUM_POINTS] = '{
        0, 250, 265, 325, 425, 645, 1560, 2975, 6790, 1000000, 1000001
    };
    localparam int POS_TABLE [NUM_POINTS] = '{
        0, 8192, 16384, 24576, 32768, 40960, 49152, 52429, 54067, 57344, 65536
    };

    // Constants of the segment that ends at breakpoint k
    typedef struct packed {
        logic signed [DIST_W-1:0] d0;
        logic        [BASE_W-1:0] base;
        logic signed [DP_W-1:0]   dp;
        logic        [D_W-1:0]    div;
    } t_seg;

    // Search result handed to the arithmetic
    typedef struct packed {
        logic signed [T_W-1:0]    offset;
        logic        [BASE_W-1:0] base;
        logic signed [DP_W-1:0]   dp;
        logic        [D_W-1:0]    div;
        logic                     beyond;
    } t_job;

    // Evaluated only with constant k at elaboration
    function automatic t_seg seg_params(input int k);
        t_seg   s;
        longint span;
        longint p0;
        longint p1;
        s = '0;
        if (k > 0) begin
            span = longint'(DIST_TABLE[k]) - longint'(DIST_TABLE[k-1]);
            p0   = longint'(POS_TABLE[k-1]);
            p1   = longint'(POS_TABLE[k]);
            s.d0 = DIST_W'(DIST_TABLE[k-1]);
            if (span <= 0) begin
                // degenerate segment: numerator p1 over SCALE_DIV
                s.base = BASE_W'(p1);
                s.dp   = '0;
                s.div  = D_W'(SCALE_DIV);
            end else begin
                s.base = BASE_W'(p0 * span);
                s.dp   = DP_W'(p1 - p0);
                s.div  = D_W'(span * SCALE_DIV);
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- sv/dtfi_search.sv -----
// Breakpoint walk: steps one breakpoint per cycle to find the segment of a distance.
// Depends on dtfi_pkg for the breakpoint tables and the t_seg / t_job types.
`timescale 1ns / 1ps
`default_nettype none

module dtfi_search (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic signed [dtfi_pkg::DIST_W-1:0] i_dist,
    output logic                                   o_done,
    output dtfi_pkg::t_job                         o_job
);
    import dtfi_pkg::*;

    localparam logic [K_W-1:0] LAST_K = K_W'(NUM_POINTS - 1);

    logic signed [DIST_W-1:0] dist_rom [NUM_POINTS];
    t_seg                     seg_rom  [NUM_POINTS];

    for (genvar g = 0; g < NUM_POINTS; g++) begin : g_rom
        assign dist_rom[g] = DIST_W'(DIST_TABLE[g]);
        assign seg_rom[g]  = seg_params(g);
    end

    logic                     r_busy;
    logic                     r_done;
    logic [K_W-1:0]           r_k;
    logic signed [DIST_W-1:0] r_dist;
    t_job                     r_job;

    logic                     d_gt;
    t_seg                     seg_sel;
    logic signed [T_W-1:0]    n_offset;

    assign d_gt     = r_dist > dist_rom[r_k];
    assign seg_sel  = seg_rom[r_k];
    assign n_offset = $signed({r_dist[DIST_W-1], r_dist}) -
                      $signed({seg_sel.d0[DIST_W-1], seg_sel.d0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
            end else if (r_busy && !(r_k < LAST_K && d_gt)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_k    <= K_W'(1);
            r_dist <= i_dist;
        end else if (r_busy) begin
            if (r_k < LAST_K && d_gt) begin
                r_k <= r_k + K_W'(1);
            end else begin
                r_job.offset <= n_offset;
                r_job.base   <= seg_sel.base;
                r_job.dp     <= seg_sel.dp;
                r_job.div    <= seg_sel.div;
                r_job.beyond <= d_gt;
            end
        end
    end

    assign o_done = r_done;
    assign o_job  = r_job;

endmodule

`default_nettype wire

// ----- sv/dtfi_mul.sv -----
// Serial signed multiplier: one bit of the position step per cycle, shift-add.
// Depends on dtfi_pkg for the operand and product widths.
`timescale 1ns / 1ps
`default_nettype none

module dtfi_mul (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic signed [dtfi_pkg::T_W-1:0]    i_a,
    input  wire logic signed [dtfi_pkg::DP_W-1:0]   i_b,
    output logic                                    o_done,
    output logic signed [dtfi_pkg::PROD_W-1:0]      o_prod
);
    import dtfi_pkg::*;

    localparam int CNT_W = $clog2(DP_W);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DP_W - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic signed [T_W-1:0] r_a;
    logic signed [T_W:0]   r_hi;
    logic [DP_W-1:0]       r_lo;

    logic signed [T_W:0]   a_ext;
    logic signed [T_W:0]   addend;
    logic signed [T_W:0]   sum;

    // The top bit of the multiplier carries negative weight
    always_comb begin
        a_ext  = {r_a[T_W-1], r_a};
        addend = '0;
        if (r_lo[0]) begin
            addend = (r_cnt == LAST_CNT) ? -a_ext : a_ext;
        end
        sum = r_hi + addend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
            end else if (r_busy && r_cnt == LAST_CNT) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_hi  <= '0;
            r_lo  <= i_b;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_hi  <= {sum[T_W], sum[T_W:1]};
            r_lo  <= {sum[0], r_lo[DP_W-1:1]};
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

`default_nettype wire

// ----- sv/dtfi_div.sv -----
// Restoring divider: one quotient bit per cycle, with an up-front overflow check.
// Depends on dtfi_pkg for the dividend, divisor and quotient widths.
`timescale 1ns / 1ps
`default_nettype none

module dtfi_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [dtfi_pkg::MAG_W-1:0]   i_mag,
    input  wire logic [dtfi_pkg::D_W-1:0]     i_div,
    output logic                              o_done,
    output logic [dtfi_pkg::Q_W-1:0]          o_quo,
    output logic                              o_ovf
);
    import dtfi_pkg::*;

    localparam int CNT_W = $clog2(Q_W);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(Q_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_div;
    logic [Q_W-1:0]   r_low;
    logic [Q_W-1:0]   r_quo;
    logic             r_ovf;

    logic [HI_W-1:0]  hi_part;
    logic             n_ovf;
    logic [D_W:0]     trial;
    logic [D_W:0]     div_ext;
    logic [D_W:0]     rem_sub;
    logic             ge;

    assign hi_part = i_mag[MAG_W-1:Q_W];
    assign n_ovf   = hi_part >= HI_W'(i_div);
    assign trial   = {r_rem, r_low[Q_W-1]};
    assign div_ext = {1'b0, r_div};
    assign ge      = trial >= div_ext;
    assign rem_sub = trial - div_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_start) begin
                // quotient would not fit: finish at once
                r_busy <= !n_ovf;
                r_done <= n_ovf;
            end else if (r_busy && r_cnt == LAST_CNT) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ovf <= n_ovf;
            r_rem <= hi_part[D_W-1:0];
            r_div <= i_div;
            r_low <= i_mag[Q_W-1:0];
            r_quo <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[D_W-1:0] : trial[D_W-1:0];
            r_low <= {r_low[Q_W-2:0], 1'b0};
            r_quo <= {r_quo[Q_W-2:0], ge};
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_ovf  = r_ovf;

endmodule

`default_nettype wire

// ----- sv/distance_to_focus_interp.sv -----
// Top level of the distance-to-focus interpolator: control sequencer and output register.
// Depends on dtfi_pkg, dtfi_search, dtfi_mul and dtfi_div.
`timescale 1ns / 1ps
`default_nettype none

// Maps a signed subject distance in millimetres to a lens focus code from 0 to
// 2048 (full travel) by linear interpolation between 11 fixed breakpoints, with
// the result truncated toward zero. Results below zero give 0 and results past
// full travel or distances beyond the last breakpoint give 2048; both set the
// clipped flag. One transaction is in work at a time, and the input is ready
// again in the same cycle that the result appears on the output. A transaction
// passes through the breakpoint walk (one breakpoint a cycle), the 18-step
// serial multiply and the 12-step restoring divide. Distances beyond the table
// skip the arithmetic. A finished result sits in an output register, so the
// next transaction is taken while it waits for the consumer.

module distance_to_focus_interp (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    input  wire logic [dtfi_pkg::IN_TDATA_W-1:0]        s_axis_tdata,  // [20:0] distance_mm
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    output logic [dtfi_pkg::OUT_TDATA_W-1:0]            m_axis_tdata,  // [11:0] focus_code
    output logic                                        m_axis_tuser   // [0] clipped
);
    import dtfi_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_MUL    = 6'b000100,
        S_ABS    = 6'b001000,
        S_DIV    = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic                     in_accept;
    logic                     search_done;
    t_job                     job;
    logic                     mul_start;
    logic                     mul_done;
    logic signed [PROD_W-1:0] mul_prod;
    logic                     div_done;
    logic [Q_W-1:0]           div_quo;
    logic                     div_ovf;

    logic signed [X_W-1:0]    r_x;
    logic                     r_neg;
    logic [MAG_W-1:0]         r_mag;
    logic                     r_div_go;
    logic [FOCUS_W-1:0]       r_res_code;
    logic                     r_res_clip;
    logic                     r_out_valid;
    logic [FOCUS_W-1:0]       r_out_code;
    logic                     r_out_clip;

    logic signed [X_W-1:0]    base_ext;
    logic signed [X_W-1:0]    x_neg;
    logic                     out_load;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign mul_start = (r_state == S_SEARCH) && search_done && !job.beyond;
    assign base_ext  = $signed({{(X_W - BASE_W){1'b0}}, job.base});
    assign x_neg     = -r_x;
    assign out_load  = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    dtfi_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_accept),
        .i_dist  (s_axis_tdata[DIST_W-1:0]),
        .o_done  (search_done),
        .o_job   (job)
    );

    dtfi_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (job.offset),
        .i_b     (job.dp),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    dtfi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_mag   (r_mag),
        .i_div   (job.div),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_ovf   (div_ovf)
    );

    // Sequencer: walk, multiply, take magnitude, divide, hand off; if beyond, hand off
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_accept) n_state = S_SEARCH;
            S_SEARCH: if (search_done) n_state = job.beyond ? S_DONE : S_MUL;
            S_MUL:    if (mul_done) n_state = S_ABS;
            S_ABS:    n_state = S_DIV;
            S_DIV:    if (div_done) n_state = S_DONE;
            S_DONE:   if (out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_div_go <= (r_state == S_ABS);
            // reload when the next one is ready, drop the result once taken
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL && mul_done) begin
            r_x <= mul_prod + base_ext;
        end
        if (r_state == S_ABS) begin
            r_neg <= r_x[X_W-1];
            r_mag <= r_x[X_W-1] ? x_neg[MAG_W-1:0] : r_x[MAG_W-1:0];
        end
        if (r_state == S_SEARCH && search_done && job.beyond) begin
            r_res_code <= OUT_CODE;
            r_res_clip <= 1'b1;
        end else if (r_state == S_DIV && div_done) begin
            if (r_neg) begin
                // a nonzero negative quotient clamps to zero
                r_res_code <= '0;
                r_res_clip <= div_ovf || (div_quo != '0);
            end else if (div_ovf || div_quo > OUT_CODE) begin
                r_res_code <= OUT_CODE;
                r_res_clip <= 1'b1;
            end else begin
                r_res_code <= div_quo;
                r_res_clip <= 1'b0;
            end
        end
        if (out_load) begin
            r_out_code <= r_res_code;
            r_out_clip <= r_res_clip;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - FOCUS_W){1'b0}}, r_out_code};
    assign m_axis_tuser  = r_out_clip;

    // Checks
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_SEARCH))
        else $error("accepted transaction did not start the breakpoint walk");

    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_MUL))
        else $error("multiplier finished outside the multiply phase");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide phase");

    a_clip_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_clip) |-> (r_out_code == '0 || r_out_code == OUT_CODE))
        else $error("clipped result is not at either end of travel");

endmodule

`default_nettype wire
